// File: rtl/pso_pkg.sv
package pso_pkg;

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_BEGIN  = 3'd2,
    CMD_REPORT = 3'd3,
    CMD_UPDATE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_CP     = 3'd1,
    REG_CG     = 3'd2,
    REG_LO     = 3'd3,
    REG_HI     = 3'd4,
    REG_TOTAL  = 3'd5,
    REG_DIMS   = 3'd6,
    REG_PARTS  = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_ADAPT  = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RPT_CMP,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_RPT_OUT,
    ST_W_START,
    ST_W_WAIT,
    ST_W_DIV2,
    ST_W_WAIT2,
    ST_W_DONE,
    ST_CR_P,
    ST_CR_G,
    ST_D_RD,
    ST_D_LAT,
    ST_D_MUL_W,
    ST_D_MUL_P,
    ST_D_MUL_G,
    ST_D_SUM,
    ST_D_CLAMP,
    ST_D_OUT
  } state_e;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
    logic [6:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] quo;
  } div_rsp_t;

  localparam logic [15:0] W_HIGH = 16'd58982;
  localparam logic [15:0] W_LOW  = 16'd26214;
  localparam logic [16:0] W_HALF = 17'd32768;
  localparam logic signed [47:0] FIT_MAX = 48'sh7FFF_FFFF_FFFF;

endpackage

// File: rtl/pso_div.sv
module pso_div
  import pso_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // restoring divider, one quotient bit per cycle, top-aligned numerator
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] num_q, num_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    num_d = num_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, num_q[63]};
    if (req_i.start) begin
      rem_d = '0;
      quo_d = '0;
      num_d = req_i.num;
      den_d = req_i.den;
      cnt_d = req_i.steps;
    end else if (cnt_q != 7'd0) begin
      num_d = {num_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = 64'(trial - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = (cnt_q != 7'd0);
  assign rsp_o.quo  = quo_q;

endmodule

// File: rtl/pso_mul.sv
module pso_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  // shared signed multiplier, registered product
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// File: rtl/pso_particle_update.sv
// particle swarm update engine
// input channel: command, particle, dim_sel, position_in, fitness_in,
//   rand_personal, rand_global, generation; valid_i / stall_o handshake
// output channel: dim_out, position_out, velocity_out, best_value, last;
//   valid_o / stall_i handshake, one output register
// config channel: cfg_valid_i / cfg_ready_o with index and data, write only
//   while the block is idle
// load and begin give no word; start also reruns the clearing sweep of the
//   personal bests
// report fitness compares against both bests; when either improves it copies the
//   point per dimension (all MAX_DIMS dims), then emits one word
// update: inertia (up to two divisions in adaptive, one in linear, none in fixed),
//   then per dimension read, three products through one shared multiplier, sum,
//   clamp and output
// after reset a clearing sweep over all MAX_PARTICLES entries sets personal bests to
//   the most positive value; no word is taken meanwhile
// a stalled output word holds the sequencer in place, and stall_o stays high
//   while a word waits in the output register
module pso_particle_update
  import pso_pkg::*;
#(
  parameter int MAX_PARTICLES = 64,
  parameter int MAX_DIMS      = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [2:0]         command_i,
  input  logic [5:0]         particle_i,
  input  logic [4:0]         dim_sel_i,
  input  logic signed [31:0] position_in_i,
  input  logic signed [47:0] fitness_in_i,
  input  logic [15:0]        rand_personal_i,
  input  logic [15:0]        rand_global_i,
  input  logic [15:0]        generation_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [4:0]         dim_out_o,
  output logic signed [31:0] position_out_o,
  output logic signed [31:0] velocity_out_o,
  output logic signed [47:0] best_value_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW = PW + DW;
  localparam int ND = MAX_DIMS < 32 ? MAX_DIMS : 32;

  // configuration registers
  logic [1:0]         mode_q;
  logic [15:0]        cp_q, cg_q, total_q;
  logic signed [31:0] lo_q, hi_q;
  logic [5:0]         dims_q;
  logic [6:0]         parts_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FIXED;
      cp_q    <= 16'd24412;
      cg_q    <= 16'd24412;
      lo_q    <= -32'sd335544;
      hi_q    <= 32'sd335544;
      total_q <= 16'd100;
      dims_q  <= 6'd2;
      parts_q <= 7'd64;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_MODE:  mode_q  <= cfg_data_i[1:0];
        REG_CP:    cp_q    <= cfg_data_i[15:0];
        REG_CG:    cg_q    <= cfg_data_i[15:0];
        REG_LO:    lo_q    <= cfg_data_i;
        REG_HI:    hi_q    <= cfg_data_i;
        REG_TOTAL: total_q <= cfg_data_i[15:0];
        REG_DIMS:  dims_q  <= cfg_data_i[5:0];
        REG_PARTS: parts_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // memories: positions, velocities, personal best points, global best point,
  // personal best values, particle fitness
  logic signed [31:0] pos_mem [MAX_PARTICLES*MAX_DIMS];
  logic signed [31:0] vel_mem [MAX_PARTICLES*MAX_DIMS];
  logic signed [31:0] pb_mem  [MAX_PARTICLES*MAX_DIMS];
  logic signed [31:0] gb_mem  [MAX_DIMS];
  logic signed [47:0] pbv_mem [MAX_PARTICLES];
  logic signed [47:0] fit_mem [MAX_PARTICLES];

  logic [AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] gb_addr;
  logic [PW-1:0] pv_addr;
  logic          pos_we, vel_we, pb_we, gb_we, pbv_we, fit_we;
  logic signed [31:0] pos_wd, vel_wd, pb_wd, gb_wd;
  logic signed [47:0] pbv_wd, fit_wd;
  logic signed [31:0] pos_rd_q, vel_rd_q, pb_rd_q, gb_rd_q;
  logic signed [47:0] pbv_rd_q, fit_rd_q;

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[wr_addr] <= pos_wd;
    if (vel_we) vel_mem[wr_addr] <= vel_wd;
    if (pb_we)  pb_mem[wr_addr]  <= pb_wd;
    if (gb_we)  gb_mem[gb_addr]  <= gb_wd;
    if (pbv_we) pbv_mem[pv_addr] <= pbv_wd;
    if (fit_we) fit_mem[pv_addr] <= fit_wd;
    pos_rd_q <= pos_mem[rd_addr];
    vel_rd_q <= vel_mem[rd_addr];
    pb_rd_q  <= pb_mem[rd_addr];
    gb_rd_q  <= gb_mem[gb_addr];
    pbv_rd_q <= pbv_mem[pv_addr];
    fit_rd_q <= fit_mem[pv_addr];
  end

  // sequencer state
  state_e state_q, state_d;
  logic [PW-1:0] part_q, part_d;
  logic [DW:0]   k_q, k_d;
  logic [5:0]    n_q, n_d;
  logic signed [47:0] fin_q, fin_d;
  logic [15:0]   r1_q, r1_d, r2_q, r2_d, gen_q, gen_d;
  logic signed [47:0] gbv_q, gbv_d;
  logic signed [53:0] sum_q, sum_d;
  logic          newp_q, newp_d, newg_q, newg_d;
  logic [15:0]   w_q, w_d;
  logic signed [33:0] crp_q, crp_d, crg_q, crg_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] x_q, x_d;
  logic signed [33:0] vv_q, vv_d, dp_q, dp_d, dg_q, dg_d;
  logic signed [47:0] fp_q, fp_d;
  logic signed [63:0] avg_q, avg_d;

  // output register
  logic               ov_q, ov_d;
  logic [4:0]         od_q, od_d;
  logic signed [31:0] op_q, op_d, ovl_q, ovl_d;
  logic               ol_q, ol_d;

  // shared units
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;

  pso_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  pso_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  logic [DW-1:0] kidx;
  assign kidx = k_q[DW-1:0];

  // combinational helpers
  logic [15:0]        tg, gsat;
  logic [6:0]         np_cnt;
  logic signed [63:0] sum64, num64, den64;
  logic signed [63:0] vsum, newp, vcor;
  logic [5:0]         dn;

  always_comb begin
    tg     = (total_q == 16'd0) ? 16'd1 : total_q;
    gsat   = (gen_q > tg) ? tg : gen_q;
    np_cnt = (parts_q == 7'd0) ? 7'd1 : parts_q;
    sum64  = 64'(sum_q);
    num64  = 64'(fp_q) - 64'(gbv_q);
    den64  = avg_q - 64'(gbv_q);
    dn     = (dims_q == 6'd0) ? 6'd1 : dims_q;
    if (dn > 6'(ND)) dn = 6'(ND);
    vsum   = acc_q;
    newp   = 64'(x_q) + vsum;
    vcor   = vsum;
    if (newp > 64'(hi_q)) vcor = vsum - (newp - 64'(hi_q));
    else if (newp < 64'(lo_q)) vcor = vsum - (newp - 64'(lo_q));
  end

  assign stall_o = (state_q != ST_IDLE) || ov_q;
  assign valid_o = ov_q;
  assign dim_out_o = od_q;
  assign position_out_o = op_q;
  assign velocity_out_o = ovl_q;
  assign best_value_o = gbv_q;
  assign last_o = ol_q;

  always_comb begin
    state_d = state_q;
    part_d = part_q; k_d = k_q; n_d = n_q;
    fin_d = fin_q; r1_d = r1_q; r2_d = r2_q; gen_d = gen_q;
    gbv_d = gbv_q; sum_d = sum_q; newp_d = newp_q; newg_d = newg_q;
    w_d = w_q; crp_d = crp_q; crg_d = crg_q; acc_d = acc_q; x_d = x_q;
    vv_d = vv_q; dp_d = dp_q; dg_d = dg_q; fp_d = fp_q; avg_d = avg_q;
    ov_d = ov_q; od_d = od_q; op_d = op_q; ovl_d = ovl_q; ol_d = ol_q;
    dreq = '0;
    ma = '0; mb = '0;
    rd_addr = {part_q, kidx};
    wr_addr = {part_q, kidx};
    gb_addr = kidx;
    pv_addr = part_q;
    pos_we = 1'b0; vel_we = 1'b0; pb_we = 1'b0; gb_we = 1'b0;
    pbv_we = 1'b0; fit_we = 1'b0;
    pos_wd = pos_rd_q; vel_wd = '0; pb_wd = pos_rd_q; gb_wd = pos_rd_q;
    pbv_wd = FIT_MAX; fit_wd = fin_q;

    if (ov_q && !stall_i) ov_d = 1'b0;

    case (state_q)
      ST_SWEEP: begin
        pbv_we = 1'b1;
        if (part_q == PW'(MAX_PARTICLES - 1)) state_d = ST_IDLE;
        else part_d = part_q + PW'(1);
      end
      ST_IDLE: begin
        if (valid_i && !ov_q) begin
          fin_d = fitness_in_i; r1_d = rand_personal_i; r2_d = rand_global_i;
          gen_d = generation_i; part_d = PW'(particle_i); k_d = '0;
          if (32'(particle_i) < 32'(MAX_PARTICLES)) begin
            case (cmd_e'(command_i))
              CMD_START: begin
                gbv_d = FIT_MAX; part_d = '0; state_d = ST_SWEEP;
              end
              CMD_LOAD: begin
                if (32'(dim_sel_i) < 32'(MAX_DIMS)) begin
                  wr_addr = {PW'(particle_i), DW'(dim_sel_i)};
                  pos_we = 1'b1; pb_we = 1'b1; vel_we = 1'b1;
                  pos_wd = position_in_i; pb_wd = position_in_i; vel_wd = '0;
                end
              end
              CMD_BEGIN: sum_d = '0;
              CMD_REPORT: begin
                pv_addr = PW'(particle_i);
                state_d = ST_RPT_CMP;
              end
              CMD_UPDATE: begin
                pv_addr = PW'(particle_i);
                state_d = ST_W_START;
              end
              default: ;
            endcase
          end
        end
      end
      ST_RPT_CMP: begin
        fit_we = 1'b1;
        sum_d = 54'(sum_q + 54'(fin_q));
        newp_d = fin_q < pbv_rd_q;
        newg_d = fin_q < gbv_q;
        if (fin_q < pbv_rd_q) begin
          pbv_we = 1'b1; pbv_wd = fin_q;
        end
        if (fin_q < gbv_q) gbv_d = fin_q;
        k_d = '0;
        state_d = ((fin_q < pbv_rd_q) || (fin_q < gbv_q)) ? ST_COPY_RD : ST_RPT_OUT;
      end
      ST_COPY_RD: state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        pb_we = newp_q; gb_we = newg_q;
        if (k_q == (DW+1)'(MAX_DIMS - 1)) state_d = ST_RPT_OUT;
        else begin
          k_d = k_q + 1'b1; state_d = ST_COPY_RD;
        end
      end
      ST_RPT_OUT: begin
        if (!ov_q || !stall_i) begin
          ov_d = 1'b1; od_d = '0; op_d = '0; ovl_d = '0; ol_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_W_START: begin
        fp_d = fit_rd_q;
        case (mode_q)
          MODE_FIXED: begin
            w_d = W_HIGH; state_d = ST_CR_P;
          end
          MODE_LINEAR: begin
            dreq.start = 1'b1;
            dreq.num = {32'd0, 32'(gsat) * 32'(W_HALF)};
            dreq.den = 64'(tg);
            dreq.steps = 7'd64;
            state_d = ST_W_WAIT;
          end
          default: begin
            // average = sum / n, sign handled on the magnitude
            dreq.start = 1'b1;
            dreq.num = sum64[63] ? 64'(-sum64) : sum64;
            dreq.den = 64'(np_cnt);
            dreq.steps = 7'd64;
            state_d = ST_W_WAIT;
          end
        endcase
      end
      ST_W_WAIT: begin
        if (!drsp.busy) begin
          if (mode_q == MODE_LINEAR) begin
            w_d = 16'(W_HIGH - 16'(drsp.quo));
            state_d = ST_CR_P;
          end else begin
            avg_d = sum64[63] ? -$signed(drsp.quo) : $signed(drsp.quo);
            state_d = ST_W_DIV2;
          end
        end
      end
      ST_W_DIV2: begin
        if (avg_q < 64'(fp_q)) begin
          w_d = W_HIGH; state_d = ST_CR_P;
        end else if (den64 <= 0 || num64 <= 0) begin
          w_d = W_LOW; state_d = ST_CR_P;
        end else if (num64 >= den64) begin
          w_d = 16'(W_LOW + W_HALF); state_d = ST_CR_P;
        end else begin
          dreq.start = 1'b1;
          dreq.num = {num64[48:0], 15'd0};
          dreq.den = den64;
          dreq.steps = 7'd64;
          state_d = ST_W_WAIT2;
        end
      end
      ST_W_WAIT2: begin
        if (!drsp.busy) state_d = ST_W_DONE;
      end
      ST_W_DONE: begin
        w_d = 16'(W_LOW + 16'(drsp.quo));
        state_d = ST_CR_P;
      end
      ST_CR_P: begin
        ma = 34'(cp_q); mb = 34'(r1_q);
        state_d = ST_CR_G;
      end
      ST_CR_G: begin
        crp_d = 34'(mp >>> 14);
        ma = 34'(cg_q); mb = 34'(r2_q);
        n_d = dn; k_d = '0;
        state_d = ST_D_RD;
      end
      ST_D_RD: begin
        if (k_q == '0) crg_d = 34'(mp >>> 14);
        state_d = ST_D_LAT;
      end
      ST_D_LAT: begin
        x_d = pos_rd_q;
        vv_d = 34'(vel_rd_q);
        dp_d = 34'(pb_rd_q) - 34'(pos_rd_q);
        dg_d = 34'(gb_rd_q) - 34'(pos_rd_q);
        state_d = ST_D_MUL_W;
      end
      ST_D_MUL_W: begin
        ma = 34'(w_q); mb = vv_q;
        state_d = ST_D_MUL_P;
      end
      ST_D_MUL_P: begin
        acc_d = 64'(mp >>> 16);
        ma = crp_q; mb = dp_q;
        state_d = ST_D_MUL_G;
      end
      ST_D_MUL_G: begin
        acc_d = acc_q + 64'(mp >>> 16);
        ma = crg_q; mb = dg_q;
        state_d = ST_D_SUM;
      end
      ST_D_SUM: begin
        acc_d = acc_q + 64'(mp >>> 16);
        state_d = ST_D_CLAMP;
      end
      ST_D_CLAMP: begin
        if (newp > 64'(hi_q)) x_d = hi_q;
        else if (newp < 64'(lo_q)) x_d = lo_q;
        else x_d = 32'(newp);
        if (vcor > 64'sd2147483647) acc_d = 64'sd2147483647;
        else if (vcor < -64'sd2147483648) acc_d = -64'sd2147483648;
        else acc_d = vcor;
        state_d = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (!ov_q || !stall_i) begin
          pos_we = 1'b1; vel_we = 1'b1;
          pos_wd = x_q; vel_wd = 32'(acc_q);
          ov_d = 1'b1; od_d = 5'(k_q); op_d = x_q; ovl_d = 32'(acc_q);
          ol_d = (6'(k_q) + 6'd1 == n_q);
          if (6'(k_q) + 6'd1 == n_q) state_d = ST_IDLE;
          else begin
            k_d = k_q + 1'b1; state_d = ST_D_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      part_q  <= '0;
      k_q     <= '0;
      gbv_q   <= FIT_MAX;
      sum_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      part_q  <= part_d;
      k_q     <= k_d;
      gbv_q   <= gbv_d;
      sum_q   <= sum_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; fin_q <= fin_d;
    r1_q <= r1_d; r2_q <= r2_d; gen_q <= gen_d; newp_q <= newp_d; newg_q <= newg_d;
    w_q <= w_d; crp_q <= crp_d; crg_q <= crg_d; acc_q <= acc_d; x_q <= x_d;
    vv_q <= vv_d; dp_q <= dp_d; dg_q <= dg_d; fp_q <= fp_d; avg_q <= avg_d;
    od_q <= od_d; op_q <= op_d; ovl_q <= ovl_d; ol_q <= ol_d;
  end

endmodule

// File: sim/pso_particle_update_tb.sv
`timescale 1ns / 100ps

module pso_particle_update_tb;
  import pso_pkg::*;

  localparam int NPART = 64;
  localparam int NDIM = 32;
  localparam int RAND_PER_PHASE = 40;
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLD_CYCLES = 900;
  localparam longint CYCLE_LIMIT = 3000000;

  // one command word on the input channel
  typedef struct {
    logic [2:0]         cmd;
    logic [5:0]         particle;
    logic [4:0]         dim;
    logic signed [31:0] pos;
    logic signed [47:0] fit;
    logic [15:0]        r1;
    logic [15:0]        r2;
    logic [15:0]        gen;
  } cmd_word_t;

  // one element word on the output channel
  typedef struct {
    logic [4:0]         dim;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [47:0] best;
    logic               last;
  } elem_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               valid_i = 1'b0;
  logic               stall_o;
  logic [2:0]         command_i = '0;
  logic [5:0]         particle_i = '0;
  logic [4:0]         dim_sel_i = '0;
  logic signed [31:0] position_in_i = '0;
  logic signed [47:0] fitness_in_i = '0;
  logic [15:0]        rand_personal_i = '0;
  logic [15:0]        rand_global_i = '0;
  logic [15:0]        generation_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [4:0]         dim_out_o;
  logic signed [31:0] position_out_o;
  logic signed [31:0] velocity_out_o;
  logic signed [47:0] best_value_o;
  logic               last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  pso_particle_update uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .command_i      (command_i),
    .particle_i     (particle_i),
    .dim_sel_i      (dim_sel_i),
    .position_in_i  (position_in_i),
    .fitness_in_i   (fitness_in_i),
    .rand_personal_i(rand_personal_i),
    .rand_global_i  (rand_global_i),
    .generation_i   (generation_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .dim_out_o      (dim_out_o),
    .position_out_o (position_out_o),
    .velocity_out_o (velocity_out_o),
    .best_value_o   (best_value_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // swarm mirror: state of the engine as the predictor sees it
  longint sw_pos [NPART*NDIM];
  longint sw_vel [NPART*NDIM];
  longint sw_pbest_pos [NPART*NDIM];
  longint sw_pbest_val [NPART];
  longint sw_gbest_pos [NDIM];
  longint sw_gbest_val;
  longint sw_fit [NPART];
  longint sw_fit_sum;

  // register mirror
  logic [1:0]  m_mode = MODE_FIXED;
  logic [15:0] m_cp = 16'd24412;
  logic [15:0] m_cg = 16'd24412;
  logic [31:0] m_lo = -32'sd335544;
  logic [31:0] m_hi = 32'sd335544;
  logic [15:0] m_total = 16'd100;
  logic [5:0]  m_dims = 6'd2;
  logic [6:0]  m_parts = 7'd64;

  cmd_word_t  cmd_q[$];
  elem_word_t elem_q[$];
  cmd_word_t  on_bus;
  int         errors = 0;

  // traffic shaping, written by the sequence with nonblocking assignments
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // q15 fraction by restoring division, num < den
  function automatic longint q15_frac(longint num, longint den);
    longint rem;
    longint q;
    rem = num;
    q = 0;
    for (int i = 0; i < 15; i++) begin
      rem = rem <<< 1;
      q = q <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint inertia_weight(int p, logic [15:0] gen);
    longint t;
    longint g;
    longint n;
    longint avg;
    longint num;
    longint den;
    if (m_mode == MODE_FIXED) return longint'(W_HIGH);
    if (m_mode == MODE_LINEAR) begin
      t = (m_total == 0) ? 1 : longint'(m_total);
      g = (longint'(gen) > t) ? t : longint'(gen);
      return longint'(W_HIGH) - (g * longint'(W_HALF)) / t;
    end
    // adaptive, mode 3 included
    n = (m_parts == 0) ? 1 : longint'(m_parts);
    avg = sw_fit_sum / n;
    if (avg < sw_fit[p]) return longint'(W_HIGH);
    num = sw_fit[p] - sw_gbest_val;
    den = avg - sw_gbest_val;
    if (den <= 0 || num <= 0) return longint'(W_LOW);
    if (num >= den) return longint'(W_LOW) + longint'(W_HALF);
    return longint'(W_LOW) + q15_frac(num, den);
  endfunction

  // advance the swarm mirror by one accepted command and queue its elements
  task automatic advance_swarm(cmd_word_t c);
    int         p;
    int         base;
    int         n;
    longint     f;
    longint     w;
    longint     crp;
    longint     crg;
    longint     lo;
    longint     hi;
    longint     x;
    longint     v;
    longint     np;
    longint     s;
    elem_word_t e;
    p = c.particle;
    base = p * NDIM;
    case (c.cmd)
      CMD_START: begin
        for (int k = 0; k < NPART; k++) sw_pbest_val[k] = longint'(FIT_MAX);
        sw_gbest_val = longint'(FIT_MAX);
      end
      CMD_LOAD: begin
        sw_pos[base + c.dim] = longint'(c.pos);
        sw_pbest_pos[base + c.dim] = longint'(c.pos);
        sw_vel[base + c.dim] = 0;
      end
      CMD_BEGIN: sw_fit_sum = 0;
      CMD_REPORT: begin
        f = longint'(c.fit);
        sw_fit[p] = f;
        s = sw_fit_sum + f;
        sw_fit_sum = (s <<< 10) >>> 10;  // wraps in 54 bits
        if (f < sw_pbest_val[p]) begin
          sw_pbest_val[p] = f;
          for (int k = 0; k < NDIM; k++) sw_pbest_pos[base + k] = sw_pos[base + k];
        end
        if (f < sw_gbest_val) begin
          sw_gbest_val = f;
          for (int k = 0; k < NDIM; k++) sw_gbest_pos[k] = sw_pos[base + k];
        end
        e.dim = '0;
        e.pos = '0;
        e.vel = '0;
        e.best = sw_gbest_val[47:0];
        e.last = 1'b1;
        elem_q = {elem_q, e};
      end
      CMD_UPDATE: begin
        w = inertia_weight(p, c.gen);
        crp = (longint'(m_cp) * longint'(c.r1)) >>> 14;
        crg = (longint'(m_cg) * longint'(c.r2)) >>> 14;
        lo = longint'($signed(m_lo));
        hi = longint'($signed(m_hi));
        n = (m_dims == 0) ? 1 : ((m_dims > NDIM) ? NDIM : int'(m_dims));
        for (int k = 0; k < n; k++) begin
          x = sw_pos[base + k];
          v = ((w * sw_vel[base + k]) >>> 16)
            + ((crp * (sw_pbest_pos[base + k] - x)) >>> 16)
            + ((crg * (sw_gbest_pos[k] - x)) >>> 16);
          np = x + v;
          if (np > hi) begin
            v = v - (np - hi);
            np = hi;
          end else if (np < lo) begin
            v = v - (np - lo);
            np = lo;
          end
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          sw_pos[base + k] = np;
          sw_vel[base + k] = v;
          e.dim = k[4:0];
          e.pos = np[31:0];
          e.vel = v[31:0];
          e.best = sw_gbest_val[47:0];
          e.last = (k == n - 1);
          elem_q = {elem_q, e};
        end
      end
      default: ;  // unknown command words are dropped
    endcase
  endtask

  // driver: offers queued command words, holds a word until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin
      if (valid_i && !stall_o) advance_swarm(on_bus);
      if (!valid_i || !stall_o) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = cmd_q.pop_front();
          command_i <= on_bus.cmd;
          particle_i <= on_bus.particle;
          dim_sel_i <= on_bus.dim;
          position_in_i <= on_bus.pos;
          fitness_in_i <= on_bus.fit;
          rand_personal_i <= on_bus.r1;
          rand_global_i <= on_bus.r2;
          generation_i <= on_bus.gen;
          valid_i <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls plus one long hold-off, checks each element word
  always @(posedge clk_i) begin
    elem_word_t e;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (elem_q.size() == 0) begin
          $display("%0t: unexpected word dim=%0d pos=%0d vel=%0d best=%0d last=%0b",
                   $time, dim_out_o, position_out_o, velocity_out_o, best_value_o, last_o);
          errors++;
        end else begin
          e = elem_q.pop_front();
          if (dim_out_o !== e.dim) begin
            $display("%0t: dim expected %0d got %0d", $time, e.dim, dim_out_o);
            errors++;
          end
          if (position_out_o !== e.pos) begin
            $display("%0t: position expected %0d got %0d", $time, e.pos, position_out_o);
            errors++;
          end
          if (velocity_out_o !== e.vel) begin
            $display("%0t: velocity expected %0d got %0d", $time, e.vel, velocity_out_o);
            errors++;
          end
          if (best_value_o !== e.best) begin
            $display("%0t: best expected %0d got %0d", $time, e.best, best_value_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last expected %0b got %0b", $time, e.last, last_o);
            errors++;
          end
        end
      end
      // long hold-off so the engine backs up into its input
      if (hold_req && hold_left == 0) hold_left <= HOLD_CYCLES;
      else if (hold_left > 1) hold_left <= hold_left - 1;
      else if (hold_left == 1) hold_left <= -1;  // done, never again
      stall_i <= (hold_left > 1 || (hold_req && hold_left == 0)) ? 1'b1
                 : ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, elem_q.size());
      $display("** pso_particle_update: FAILED **");
      $finish;
    end
  end

  // generator bookkeeping: which elements hold a loaded value
  bit elem_loaded [NPART*NDIM];
  bit fit_known [NPART];
  bit gbest_known = 1'b0;

  function automatic int dims_now();
    return (m_dims == 0) ? 1 : ((m_dims > NDIM) ? NDIM : int'(m_dims));
  endfunction

  function automatic bit all_loaded(int p, int n);
    for (int k = 0; k < n; k++) if (!elem_loaded[p*NDIM + k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [47:0] any_fitness();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return r[47:0];
      1: return 48'sh7FFF_FFFF_FFFF;
      2: return 48'sh8000_0000_0000;
      default: return $signed(r[21:0]);
    endcase
  endfunction

  function automatic logic signed [31:0] any_position();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(5) == 0) return r;
    return $signed(r[20:0]);
  endfunction

  task automatic push_cmd(logic [2:0] cmd, int p, int d, logic signed [31:0] pos,
                          logic signed [47:0] fit, logic [15:0] r1, logic [15:0] r2,
                          logic [15:0] gen);
    cmd_word_t c;
    c.cmd = cmd;
    c.particle = p[5:0];
    c.dim = d[4:0];
    c.pos = pos;
    c.fit = fit;
    c.r1 = r1;
    c.r2 = r2;
    c.gen = gen;
    if (cmd == CMD_LOAD) elem_loaded[p*NDIM + d] = 1'b1;
    if (cmd == CMD_REPORT) begin
      fit_known[p] = 1'b1;
      if (fit != 48'sh7FFF_FFFF_FFFF) gbest_known = 1'b1;
    end
    cmd_q = {cmd_q, c};
  endtask

  // one random word; mostly legal generations, some noise
  task automatic push_random();
    int k;
    int p;
    k = $urandom_range(99);
    p = ($urandom_range(3) == 0) ? $urandom_range(NPART - 1) : $urandom_range(7);
    if (k < 4) begin
      push_cmd(CMD_START, p, 0, 0, 0, 0, 0, 0);
    end else if (k < 8) begin
      push_cmd(3'($urandom_range(7, 5)), p, $urandom_range(31), any_position(),
               any_fitness(), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (k < 20) begin
      push_cmd(CMD_LOAD, p, $urandom_range(31), any_position(), 0, 0, 0, 0);
    end else if (k < 28) begin
      push_cmd(CMD_BEGIN, p, 0, 0, 0, 0, 0, 0);
    end else if (k < 58 || !gbest_known) begin
      if (!all_loaded(p, NDIM)) p = $urandom_range(3);
      push_cmd(CMD_REPORT, p, $urandom_range(31), 0, any_fitness(), 0, 0, 0);
    end else begin
      if (!all_loaded(p, dims_now()) || (m_mode >= MODE_ADAPT && !fit_known[p]))
        p = $urandom_range(3);
      if (m_mode >= MODE_ADAPT && !fit_known[p]) begin
        // report copies the whole point, so only a fully loaded particle
        p = $urandom_range(3);
        push_cmd(CMD_REPORT, p, 0, 0, any_fitness(), 0, 0, 0);
      end else
        push_cmd(CMD_UPDATE, p, $urandom_range(31), 0, 0,
                 ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
                 ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(300)));
    end
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MODE:  m_mode = data[1:0];
      REG_CP:    m_cp = data[15:0];
      REG_CG:    m_cg = data[15:0];
      REG_LO:    m_lo = data;
      REG_HI:    m_hi = data;
      REG_TOTAL: m_total = data[15:0];
      REG_DIMS:  m_dims = data[5:0];
      default:   m_parts = data[6:0];
    endcase
  endtask

  // engine idle: nothing queued, nothing on the bus, nothing owed, then settle
  task automatic drain();
    while (cmd_q.size() > 0 || valid_i || elem_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // per phase: mode, cp, cg, lo, hi, total, dims, parts, idle, stall, hold
  typedef struct {
    logic [31:0] v [8];
    int          idle;
    int          stall;
    bit          hold;
  } phase_t;

  phase_t phases [6];

  initial begin
    for (int i = 0; i < NPART; i++) sw_pbest_val[i] = longint'(FIT_MAX);
    sw_gbest_val = longint'(FIT_MAX);
    sw_fit_sum = 0;
    phases[0] = '{'{MODE_FIXED, 24412, 24412, -335544, 335544, 100, 2, 64}, 0, 0, 0};
    phases[1] = '{'{MODE_LINEAR, 65535, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32, 1},
                  68, 0, 0};
    phases[2] = '{'{MODE_ADAPT, 0, 65535, -1000, 1000, 65535, 1, 127}, 0, 68, 0};
    // mode 3 behaves as adaptive; bounds inverted on purpose
    phases[3] = '{'{3, 16384, 30000, 5000, -5000, 1, 63, 0}, 22, 22, 0};
    phases[4] = '{'{MODE_ADAPT, 24412, 24412, -335544, 335544, 50, 4, 1}, 0, 0, 1};
    phases[5] = '{'{MODE_LINEAR, 8000, 40000, -3276800, 3276800, 200, 0, 8}, 22, 22, 0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill particles 0..7 so reports and updates never read empty entries
    for (int p = 0; p < 8; p++)
      for (int d = 0; d < NDIM; d++)
        push_cmd(CMD_LOAD, p, d, any_position(), 0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      for (int r = 0; r < 8; r++) write_reg(reg_e'(r), phases[ph].v[r]);
      @(posedge clk_i);
      idle_pct <= phases[ph].idle;
      stall_pct <= phases[ph].stall;
      hold_req <= phases[ph].hold;
      if (ph == 0) begin
        // directed: field extremes, every command, ignored commands
        push_cmd(CMD_START, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(CMD_REPORT, 1, 0, 0, 48'sh7FFF_FFFF_FFFF, 0, 0, 0);  // no new best
        push_cmd(CMD_REPORT, 0, 0, 0, 48'sh8000_0000_0000, 0, 0, 0);
        push_cmd(CMD_REPORT, 2, 31, 0, 48'sh8000_0000_0000, 0, 0, 0); // ties the best
        push_cmd(CMD_UPDATE, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(CMD_UPDATE, 1, 31, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(CMD_LOAD, 3, 31, 32'sh7FFF_FFFF, 0, 0, 0, 0);
        push_cmd(CMD_LOAD, 3, 0, 32'sh8000_0000, 0, 0, 0, 0);
        push_cmd(CMD_LOAD, 3, 1, 32'sh7FFF_FFFF, 0, 0, 0, 0);
        push_cmd(CMD_UPDATE, 3, 0, 0, 0, 16'hFFFF, 16'h8000, 16'd7);
        push_cmd(CMD_REPORT, 3, 0, 0, 48'sh0000_0001_0000, 0, 0, 0);
        push_cmd(CMD_UPDATE, 3, 0, 0, 0, 16'h1234, 16'hFFFF, 16'd50);
        push_cmd(3'd5, 63, 31, 32'sh7FFF_FFFF, 48'sh7FFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF);
        push_cmd(3'd6, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(3'd7, 17, 5, 0, 0, 0, 0, 0);
        push_cmd(CMD_LOAD, 63, 31, 32'sh8000_0000, 0, 0, 0, 0);
        push_cmd(CMD_START, 63, 0, 0, 0, 0, 0, 0);
        push_cmd(CMD_REPORT, 5, 0, 0, 48'sh7FFF_FFFF_FFFE, 0, 0, 0);
        push_cmd(CMD_UPDATE, 5, 0, 0, 0, 16'hAAAA, 16'h5555, 16'd100);
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) push_random();
    end

    drain();
    if (errors == 0 && elem_q.size() == 0) begin
      $display("** pso_particle_update: PASSED **");
    end else begin
      $display("** pso_particle_update: FAILED **");
    end
    $finish;
  end

endmodule
